/* rtl/core/stlm_pkg.sv */
// Package: shared types and constants of the sorted timer list manager.
`timescale 1ns / 1ps
package stlm_pkg;
  localparam int OPCODE_W = 3;
  localparam int SLOT_W = 6;
  localparam int QUEUE_W = 4;
  localparam int DATA_W = 32;
  localparam int KIND_W = 2;
  localparam int MAX_OUT = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 3'd0, OP_FREE = 3'd1, OP_INIT = 3'd2, OP_SETTIME = 3'd3, OP_TICK = 3'd4
  } op_t;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  localparam logic [31:0] NO_DUE = 32'hffffffff;

  // One command word on the input channel.
  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [SLOT_W-1:0]        slot;
    logic [QUEUE_W-1:0]       queue_id;
    logic signed [DATA_W-1:0] payload;
    logic [DATA_W-1:0]        delay;
  } cmd_word_t;

  // One reply word on the output channel.
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic                     ok;
    logic [SLOT_W-1:0]        slot_out;
    logic [QUEUE_W-1:0]       queue_out;
    logic signed [DATA_W-1:0] data_out;
    logic                     last;
  } reply_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_WALK_RD, S_WALK, S_LINK, S_TICK_RD, S_TICK, S_DUE_RD,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input word
    logic scan_step; // test one slot for free
    logic rd_head;   // read deadline and link of the head
    logic rd_walk;   // read entry after walk pointer
    logic walk_adv;  // advance the walk pointer
    logic do_simple; // finish free / init / settime check
    logic ins_head;  // insert at list head
    logic ins_after; // insert after walk pointer
    logic tick_inc;  // advance tick count
    logic pop;       // deliver head entry
    logic set_due;   // reload next_due from the entry after the head
    logic emit;      // present a result word
    logic emit_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic scan_hit;
    logic scan_end;
    logic arm_ok;    // settime on an allocated in-range slot
    logic empty;
    logic head_first;// new deadline goes at head
    logic walk_stop; // insert after walk pointer
    logic due;       // tick has deliveries
    logic head_due;  // head is due now
    logic cnt_full;  // delivered MAX_OUT words
    logic pop_last;  // delivering the head ends this tick
    logic out_busy;  // output register full and not taken
  } stat_t;
endpackage

/* rtl/core/stlm_if.sv */
// Interface: valid/ready channel carrying one word.
`timescale 1ns / 1ps
interface stlm_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/stlm_ctrl.sv */
// Controller state machine of the sorted timer list manager.
`timescale 1ns / 1ps
module stlm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  stlm_pkg::stat_t st,
  output stlm_pkg::cmd_t  cmd
);
  import stlm_pkg::*;
  state_t state, state_next, ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
    end else begin
      state <= state_next;
      ret <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next = ret;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.op)
          OP_ALLOC: state_next = S_SCAN;
          OP_TICK: begin
            cmd.tick_inc = 1'b1;
            cmd.rd_head = 1'b1;
            state_next = S_TICK;
          end
          OP_SETTIME: begin
            if (st.arm_ok) begin
              cmd.rd_head = 1'b1;
              state_next = S_WALK_RD;
            end else begin
              cmd.do_simple = 1'b1;
              cmd.emit = 1'b1;
              cmd.emit_last = 1'b1;
              state_next = S_OUT;
              ret_next = S_IDLE;
            end
          end
          default: begin
            cmd.do_simple = 1'b1;
            cmd.emit = 1'b1;
            cmd.emit_last = 1'b1;
            state_next = S_OUT;
            ret_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_hit || st.scan_end) begin
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          state_next = S_OUT;
          ret_next = S_IDLE;
        end
      end
      S_WALK_RD: begin
        // head deadline now registered
        if (st.empty || st.head_first) begin
          cmd.ins_head = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          state_next = S_OUT;
          ret_next = S_IDLE;
        end else begin
          cmd.rd_walk = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (st.walk_stop) begin
          cmd.ins_after = 1'b1;
          state_next = S_LINK;
        end else begin
          cmd.walk_adv = 1'b1;
          cmd.rd_walk = 1'b1;
        end
      end
      S_LINK: begin
        cmd.emit = 1'b1;
        cmd.emit_last = 1'b1;
        state_next = S_OUT;
        ret_next = S_IDLE;
      end
      S_TICK: begin
        if (st.due) begin
          state_next = S_TICK_RD;
        end else begin
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          state_next = S_OUT;
          ret_next = S_IDLE;
        end
      end
      S_TICK_RD: begin
        // The delivery that ends the tick carries the last mark and reloads next_due.
        if (!st.empty && st.head_due && !st.cnt_full) begin
          cmd.pop = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_last = st.pop_last;
          cmd.set_due = st.pop_last;
          state_next = S_OUT;
          ret_next = st.pop_last ? S_IDLE : S_DUE_RD;
        end else begin
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          state_next = S_OUT;
          ret_next = S_IDLE;
        end
      end
      S_DUE_RD: begin
        cmd.rd_head = 1'b1;
        state_next = S_TICK_RD;
      end
      S_OUT: begin
        if (!st.out_busy) state_next = ret;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/core/stlm_dp.sv */
// Datapath of the sorted timer list manager: slot memories, list registers, output word.
`timescale 1ns / 1ps
module stlm_dp #(
  parameter int SLOTS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [stlm_pkg::OPCODE_W-1:0]  opcode,
  input  logic [stlm_pkg::SLOT_W-1:0]    slot,
  input  logic [stlm_pkg::QUEUE_W-1:0]   queue_id,
  input  logic signed [stlm_pkg::DATA_W-1:0] payload,
  input  logic [stlm_pkg::DATA_W-1:0]    delay,
  input  stlm_pkg::cmd_t                 cmd,
  output stlm_pkg::stat_t                st,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [stlm_pkg::KIND_W-1:0]    kind,
  output logic                           ok,
  output logic [stlm_pkg::SLOT_W-1:0]    slot_out,
  output logic [stlm_pkg::QUEUE_W-1:0]   queue_out,
  output logic signed [stlm_pkg::DATA_W-1:0] data_out,
  output logic                           last
);
  import stlm_pkg::*;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int CW = $clog2(MAX_OUT + 1);

  logic [1:0]            slot_state [SLOTS];
  logic [31:0]           deadline_mem [SLOTS];
  logic [IW-1:0]         link_mem [SLOTS];
  logic [QUEUE_W-1:0]    queue_mem [SLOTS];
  logic [31:0]           data_mem [SLOTS];

  op_t           op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [QUEUE_W-1:0] queue_r;
  logic [31:0]   payload_r, delay_r, dl_new;
  logic [31:0]   tick_count, next_due;
  logic [IW-1:0] list_head, walk, scan_i;
  logic [LW-1:0] list_length, walk_n;
  logic [CW-1:0] out_cnt;
  logic [31:0]   rd_dl, rd_next_dl;
  logic [IW-1:0] rd_link;
  logic          ok_r, in_range;
  logic [IW-1:0] sidx;

  assign sidx = slot_r[IW-1:0];
  assign in_range = ({26'd0, slot_r} < 32'(SLOTS));
  assign dl_new = tick_count + delay_r;

  always_comb begin
    st = '0;
    st.op = op_r;
    st.scan_hit = (slot_state[scan_i] == ST_FREE);
    st.scan_end = (32'(scan_i) == 32'(SLOTS - 1));
    st.arm_ok = in_range && (slot_state[sidx] == ST_ALLOC);
    st.empty = (list_length == '0);
    st.head_first = (dl_new <= rd_dl);
    st.walk_stop = (walk_n >= list_length) || (dl_new <= rd_dl);
    st.due = (list_length != '0) && (next_due <= tick_count);
    st.head_due = (rd_dl <= tick_count);
    st.cnt_full = (out_cnt == CW'(MAX_OUT));
    st.pop_last = (list_length == LW'(1)) || (out_cnt == CW'(MAX_OUT - 1)) ||
                  (rd_next_dl > tick_count);
    st.out_busy = out_valid && !out_ready;
  end

  // Slot memories.
  always_ff @(posedge clk) begin
    if (cmd.rd_head) begin
      rd_dl <= deadline_mem[list_head];
      rd_link <= link_mem[list_head];
      rd_next_dl <= deadline_mem[link_mem[list_head]];
    end else if (cmd.rd_walk) begin
      rd_dl <= deadline_mem[link_mem[cmd.walk_adv ? rd_link : walk]];
      rd_link <= link_mem[cmd.walk_adv ? rd_link : walk];
    end
    if (cmd.do_simple && op_r == OP_INIT && in_range) begin
      queue_mem[sidx] <= queue_r;
      data_mem[sidx] <= payload_r;
    end
    if (cmd.ins_head) begin
      deadline_mem[sidx] <= dl_new;
      link_mem[sidx] <= list_head;
    end
    if (cmd.ins_after) begin
      deadline_mem[sidx] <= dl_new;
      link_mem[sidx] <= (walk_n >= list_length) ? rd_link : link_mem[walk];
      link_mem[walk] <= sidx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_state[i] <= ST_FREE;
      tick_count <= '0;
      list_head <= '0;
      list_length <= '0;
      next_due <= NO_DUE;
      out_valid <= 1'b0;
      op_r <= OP_ALLOC;
      scan_i <= '0;
      walk <= '0;
      walk_n <= '0;
      out_cnt <= '0;
      ok_r <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        op_r <= op_t'(opcode);
        scan_i <= '0;
        out_cnt <= '0;
        ok_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (st.scan_hit) begin
          slot_state[scan_i] <= ST_ALLOC;
          ok_r <= 1'b1;
        end else if (!st.scan_end) begin
          scan_i <= scan_i + 1'b1;
        end
      end
      if (cmd.do_simple && in_range) begin
        if (op_r == OP_FREE && slot_state[sidx] != ST_RUN) begin
          slot_state[sidx] <= ST_FREE;
          ok_r <= 1'b1;
        end
        if (op_r == OP_INIT) ok_r <= 1'b1;
      end
      if (cmd.rd_head && op_r == OP_SETTIME) begin
        walk <= list_head;
        walk_n <= LW'(1);
      end
      if (cmd.walk_adv) begin
        walk <= rd_link;
        walk_n <= walk_n + 1'b1;
      end
      if (cmd.ins_head || cmd.ins_after) begin
        slot_state[sidx] <= ST_RUN;
        list_length <= list_length + 1'b1;
        ok_r <= 1'b1;
      end
      if (cmd.ins_head) begin
        list_head <= sidx;
        next_due <= dl_new;
      end
      if (cmd.tick_inc) tick_count <= tick_count + 1'b1;
      if (cmd.pop) begin
        slot_state[list_head] <= ST_ALLOC;
        list_head <= rd_link;
        list_length <= list_length - 1'b1;
        out_cnt <= out_cnt + 1'b1;
      end
      // Issued with the final delivery of a tick: next_due takes the deadline of the entry after the head.
      if (cmd.set_due) next_due <= (list_length != LW'(1)) ? rd_next_dl : NO_DUE;
      if (cmd.emit) out_valid <= 1'b1;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.emit_last;
      queue_out <= '0;
      data_out <= '0;
      if (cmd.pop) begin
        kind <= KIND_EXPIRY;
        ok <= 1'b1;
        slot_out <= SLOT_W'(list_head);
        queue_out <= queue_mem[list_head];
        data_out <= data_mem[list_head];
      end else if (op_r == OP_ALLOC) begin
        kind <= KIND_ALLOC;
        ok <= st.scan_hit;
        slot_out <= st.scan_hit ? SLOT_W'(scan_i) : '0;
      end else if (op_r == OP_TICK) begin
        kind <= KIND_ACK;
        ok <= 1'b1;
        slot_out <= '0;
      end else begin
        kind <= KIND_ACK;
        ok <= cmd.ins_head ? 1'b1 : (op_r == OP_SETTIME ? ok_r : (in_range &&
              (op_r == OP_INIT || (op_r == OP_FREE && slot_state[sidx] != ST_RUN))));
        slot_out <= slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r <= slot;
      queue_r <= queue_id;
      payload_r <= payload;
      delay_r <= delay;
    end
  end
endmodule

/* rtl/core/sorted_timer_list_manager_core.sv */
// Top level of the sorted timer list manager.
`timescale 1ns / 1ps
// The block keeps a pool of SLOTS timer slots and takes one command word at a time on in_ch
// (alloc, free, init, settime or tick), answering on out_ch with one or more reply words, the
// final one carrying the last mark. Running slots sit on a list sorted by deadline, and a new
// deadline goes in front of any equal ones. Work is strictly sequential: a new word is taken
// only once every reply of the previous one has left. Alloc tests one slot after another for
// a free one; a settime that does not land at the head walks the list entry by entry; a tick
// delivers due timers from the list head, at most MAX_OUT (32) per tick. Any timers still
// due beyond that stay at the list head for the following ticks. While out_ch holds back a
// reply word, the block waits until it is taken.
module sorted_timer_list_manager_core #(
  parameter int SLOTS = 32
) (
  input logic clk,
  input logic rst,
  stlm_if.sink   in_ch,
  stlm_if.source out_ch
);
  import stlm_pkg::*;
  stlm_pkg::cmd_t  cmd;
  stlm_pkg::stat_t st;
  stlm_ctrl u_ctrl (.clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .st, .cmd);
  stlm_dp #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst, .opcode(in_ch.data.opcode), .slot(in_ch.data.slot),
    .queue_id(in_ch.data.queue_id), .payload(in_ch.data.payload),
    .delay(in_ch.data.delay), .cmd, .st, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .kind(out_ch.data.kind), .ok(out_ch.data.ok), .slot_out(out_ch.data.slot_out),
    .queue_out(out_ch.data.queue_out), .data_out(out_ch.data.data_out),
    .last(out_ch.data.last));
endmodule
